// ===== rtl/mgva_pkg.sv =====
// shared types and constants for the mic gain and voice activity unit
`default_nettype none

package mgva_pkg;

    // reset values of the settings registers
    localparam logic [7:0]  GAIN_RESET      = 8'd100;
    localparam logic        MUTE_RESET      = 1'b0;
    localparam logic [15:0] THRESHOLD_RESET = 16'd380;
    localparam logic [15:0] HOLD_RESET      = 16'd300;

    localparam logic [15:0] TICKS_SAT = 16'hFFFF;

    localparam int MAX_FRAME_SAMPLES_DEF = 1024;

    // register indexes on the settings port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MUTE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD      = 2'd3;
    localparam int CFG_DATA_W = 16;

    // floor(m / 100) == (m * RECIP_100) >> RECIP_SHIFT for every m below 2^24
    localparam logic [24:0] RECIP_100   = 25'd21474837;
    localparam int          RECIP_SHIFT = 31;

    localparam logic [16:0] POS_LIMIT = 17'd32767;
    localparam logic [16:0] NEG_LIMIT = 17'd32768;

    // queue depths: middle queue between front and back, result queue after the back
    localparam int MID_DEPTH = 8;
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH = 2;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  gain_percent;
        logic        mute;
        logic [15:0] loud_threshold;
        logic [15:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic        is_tick;
        logic        last;
        logic        valid;
        logic [15:0] out_sample;
        logic [30:0] sq;
    } mid_item_t;

    typedef struct packed {
        logic [15:0] out_sample;
        logic        sample_valid;
        logic        frame_end;
        logic        speaking;
        logic        speaking_changed;
    } res_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_MUL,
        BK_DECIDE
    } bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/mgva_fifo.sv =====
// small show-ahead queue built from registers
`default_nettype none

module mgva_fifo
    import mgva_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr,
    input  wire logic [WIDTH-1:0]               wdata,
    input  wire logic                           rd,
    output logic      [WIDTH-1:0]               rdata,
    output logic                                empty,
    output logic                                full,
    output logic      [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign count = count_reg;
    assign rdata = mem_reg[rptr_reg];

    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mgva_front.sv =====
// front pipeline: takes items, applies gain with saturation, squares the result
`default_nettype none

module mgva_front
    import mgva_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   req_type,
    input  wire logic signed [15:0]     sample,
    input  wire logic                   last_in_frame,
    input  wire cfg_t                   cfg,
    input  wire logic [MID_CNT_W-1:0]   mid_count,
    output logic                        mid_push,
    output mid_item_t                   mid_item
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        tick1_reg, tick2_reg, tick3_reg;
    logic        last1_reg, last2_reg, last3_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    logic [15:0] mag1_reg;
    logic [23:0] p2_reg;
    logic [16:0] q3_reg;

    logic [15:0] s_u;
    logic [15:0] mag_in;
    logic        accept;
    logic [MID_CNT_W:0] used;
    logic [48:0] qp;
    logic [16:0] lim;
    logic [16:0] mag_sat;
    logic [15:0] mag16;
    logic [31:0] sq_full;

    // credit check: queue entries plus items still in the pipeline
    assign used = (MID_CNT_W+1)'(mid_count) + (MID_CNT_W+1)'(v1_reg)
                + (MID_CNT_W+1)'(v2_reg) + (MID_CNT_W+1)'(v3_reg);
    assign full   = (used >= (MID_CNT_W+1)'(MID_DEPTH));
    assign accept = push && !full;

    assign s_u    = sample;
    assign mag_in = s_u[15] ? (~s_u + 16'd1) : s_u;

    assign qp = 49'(p2_reg) * 49'(RECIP_100);

    always_comb
    begin
        lim      = neg3_reg ? NEG_LIMIT : POS_LIMIT;
        mag_sat  = (q3_reg > lim) ? lim : q3_reg;
        mag16    = mag_sat[15:0];
        sq_full  = 32'(mag16) * 32'(mag16);

        mid_item.is_tick    = tick3_reg;
        mid_item.last       = last3_reg;
        mid_item.valid      = !cfg.mute;
        mid_item.sq         = sq_full[30:0];
        if (cfg.mute)
        begin
            mid_item.out_sample = '0;
        end
        else
        begin
            mid_item.out_sample = neg3_reg ? (~mag16 + 16'd1) : mag16;
        end
    end

    assign mid_push = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tick1_reg <= req_type;
        last1_reg <= last_in_frame;
        neg1_reg  <= s_u[15];
        mag1_reg  <= mag_in;

        tick2_reg <= tick1_reg;
        last2_reg <= last1_reg;
        neg2_reg  <= neg1_reg;
        p2_reg    <= 24'(mag1_reg) * 24'(cfg.gain_percent);

        tick3_reg <= tick2_reg;
        last3_reg <= last2_reg;
        neg3_reg  <= neg2_reg;
        q3_reg    <= qp[RECIP_SHIFT+16:RECIP_SHIFT];
    end

endmodule

`default_nettype wire

// ===== rtl/mgva_back.sv =====
// back end: frame energy, loudness decision, hangover counter, result build
`default_nettype none

module mgva_back
    import mgva_pkg::*;
#(
    parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       mid_empty,
    input  wire mid_item_t  mid_item,
    output logic            mid_pop,
    input  wire logic       out_full,
    output logic            out_push,
    output res_t            out_item
);

    localparam int CW = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int EW = CW + 30;
    localparam int PW = CW + 32;

    bk_state_t   state_reg, state_next;
    logic [EW-1:0] energy_reg;
    logic [CW-1:0] count_reg;
    logic [15:0]   ticks_reg;
    logic          speak_reg;
    logic [15:0]   pend_sample_reg;
    logic [31:0]   thr_sq_reg;
    logic [PW-1:0] prod_reg;

    logic          pop_ok;
    logic          is_sample;
    logic          live_last;
    logic          acc;
    logic          loud;
    logic [15:0]   ticks_dec;
    logic          speak_dec;
    logic          decide_fire;

    assign pop_ok    = !mid_empty && (mid_item.is_tick || !out_full);
    assign is_sample = !mid_item.is_tick;
    assign live_last = is_sample && mid_item.last && mid_item.valid;
    assign acc       = (state_reg == BK_RUN) && pop_ok && is_sample && mid_item.valid
                     && (count_reg < CW'(MAX_FRAME_SAMPLES));

    assign loud        = PW'(energy_reg) > prod_reg;
    assign ticks_dec   = loud ? 16'd0 : ticks_reg;
    assign speak_dec   = ticks_dec < cfg.hold_ticks;
    assign decide_fire = (state_reg == BK_DECIDE) && !out_full;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (pop_ok && live_last)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DECIDE;
            end
            BK_DECIDE:
            begin
                if (!out_full)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        mid_pop  = 1'b0;
        out_push = 1'b0;
        out_item = '0;
        case (state_reg)
            BK_RUN:
            begin
                mid_pop = pop_ok;
                if (pop_ok && is_sample && !live_last)
                begin
                    out_push                  = 1'b1;
                    out_item.out_sample       = mid_item.out_sample;
                    out_item.sample_valid     = mid_item.valid;
                    out_item.frame_end        = mid_item.last;
                    // a muted frame end forces speaking off
                    out_item.speaking         = mid_item.last ? 1'b0 : speak_reg;
                    out_item.speaking_changed = mid_item.last ? speak_reg : 1'b0;
                end
            end
            BK_MUL:
            begin
                out_push = 1'b0;
            end
            BK_DECIDE:
            begin
                out_push                  = !out_full;
                out_item.out_sample       = pend_sample_reg;
                out_item.sample_valid     = 1'b1;
                out_item.frame_end        = 1'b1;
                out_item.speaking         = speak_dec;
                out_item.speaking_changed = speak_dec ^ speak_reg;
            end
            default:
            begin
                out_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_RUN;
            energy_reg <= '0;
            count_reg  <= '0;
            ticks_reg  <= TICKS_SAT;
            speak_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_RUN && pop_ok)
            begin
                if (mid_item.is_tick)
                begin
                    if (ticks_reg != TICKS_SAT)
                    begin
                        ticks_reg <= ticks_reg + 16'd1;
                    end
                end
                else if (mid_item.last && !mid_item.valid)
                begin
                    energy_reg <= '0;
                    count_reg  <= '0;
                    speak_reg  <= 1'b0;
                end
                else if (acc)
                begin
                    energy_reg <= energy_reg + EW'(mid_item.sq);
                    count_reg  <= count_reg + CW'(1);
                end
            end
            if (decide_fire)
            begin
                ticks_reg  <= ticks_dec;
                speak_reg  <= speak_dec;
                energy_reg <= '0;
                count_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        thr_sq_reg <= 32'(cfg.loud_threshold) * 32'(cfg.loud_threshold);
        if (state_reg == BK_RUN && pop_ok && live_last)
        begin
            pend_sample_reg <= mid_item.out_sample;
        end
        if (state_reg == BK_MUL)
        begin
            prod_reg <= PW'(thr_sq_reg) * PW'(count_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mic_gain_and_voice_activity_unit.sv =====
// top level of the mic gain and voice activity unit
//
// channel   direction  handshake              payload
// input     in         push / full            req_type, sample, last_in_frame
// result    out        empty / pop            out_sample, sample_valid, frame_end,
//                                             speaking, speaking_changed
// settings  in         cfg_wr (no wait)       cfg_addr, cfg_wdata
//
// the front takes one item per cycle while full is low; a sample's result reaches the
// result ports through three pipeline stages (magnitude, gain multiply, divide by 100),
// with the square taken after the last one.
// the back retires one item per cycle while the result queue has room (ticks need none);
// a frame end holds it in the MUL and DECIDE states for the threshold multiply and compare,
// and full rises once the 8-entry middle queue plus the items still in the front fill up.
// ticks leave no result. reset loads the default settings, clears the frame energy,
// turns speaking off and saturates the hangover counter; there is no clearing pass.
`default_nettype none

module mic_gain_and_voice_activity_unit
    import mgva_pkg::*;
#(
    parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic                    req_type,
    input  wire logic signed [15:0]      sample,
    input  wire logic                    last_in_frame,
    output logic                         empty,
    input  wire logic                    pop,
    output logic signed [15:0]           out_sample,
    output logic                         sample_valid,
    output logic                         frame_end,
    output logic                         speaking,
    output logic                         speaking_changed,
    input  wire logic                    cfg_wr,
    input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata
);

    cfg_t      cfg_reg;
    mid_item_t mid_wr_item, mid_rd_item;
    logic      mid_push, mid_pop, mid_empty, mid_full;
    logic [MID_CNT_W-1:0] mid_count;
    res_t      res_wr_item, res_rd_item;
    logic      out_push, out_full;
    logic [OUT_CNT_W-1:0] out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_percent   <= GAIN_RESET;
            cfg_reg.mute           <= MUTE_RESET;
            cfg_reg.loud_threshold <= THRESHOLD_RESET;
            cfg_reg.hold_ticks     <= HOLD_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                CFG_GAIN:      cfg_reg.gain_percent   <= cfg_wdata[7:0];
                CFG_MUTE:      cfg_reg.mute           <= cfg_wdata[0];
                CFG_THRESHOLD: cfg_reg.loud_threshold <= cfg_wdata;
                CFG_HOLD:      cfg_reg.hold_ticks     <= cfg_wdata;
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    mgva_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .sample        (sample),
        .last_in_frame (last_in_frame),
        .cfg           (cfg_reg),
        .mid_count     (mid_count),
        .mid_push      (mid_push),
        .mid_item      (mid_wr_item)
    );

    mgva_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mid_push),
        .wdata (mid_wr_item),
        .rd    (mid_pop),
        .rdata (mid_rd_item),
        .empty (mid_empty),
        .full  (mid_full),
        .count (mid_count)
    );

    mgva_back #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_item  (mid_rd_item),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (res_wr_item)
    );

    mgva_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (out_push),
        .wdata (res_wr_item),
        .rd    (pop),
        .rdata (res_rd_item),
        .empty (empty),
        .full  (out_full),
        .count (out_count)
    );

    assign out_sample       = res_rd_item.out_sample;
    assign sample_valid     = res_rd_item.sample_valid;
    assign frame_end        = res_rd_item.frame_end;
    assign speaking         = res_rd_item.speaking;
    assign speaking_changed = res_rd_item.speaking_changed;

    // credit scheme must never let the front overrun the middle queue
    a_mid_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_full)
        else $error("middle queue written while full");

    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count != OUT_CNT_W'(OUT_DEPTH)))
        else $error("result queue written while full");

    a_change_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && speaking_changed) |-> frame_end)
        else $error("speaking changed outside a frame end");

    a_muted_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !sample_valid) |-> (out_sample == 16'sd0))
        else $error("muted beat carries a nonzero sample");

    a_muted_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !sample_valid && frame_end) |-> !speaking)
        else $error("muted frame end left speaking on");

endmodule

`default_nettype wire
